>>> rtl/small_risc_core_executor_assert.svh
// Assertion shorthands used by the core executor.
// Both expect a clock named clock and a synchronous reset named reset in scope.
`ifndef SMALL_RISC_CORE_EXECUTOR_ASSERT_SVH
`define SMALL_RISC_CORE_EXECUTOR_ASSERT_SVH

// Same-cycle implication.
`define SRCE_ASSERT_IMP(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define SRCE_ASSERT_NXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/srce_pkg.sv
package srce_pkg;

   localparam int unsigned DATA_W = 32;
   localparam int unsigned PC_W   = 16;

   localparam logic [1:0] OPN_WRITE = 2'd0;
   localparam logic [1:0] OPN_READ  = 2'd1;
   localparam logic [1:0] OPN_START = 2'd2;
   localparam logic [1:0] OPN_EXEC  = 2'd3;

   localparam logic [4:0] OPC_ADD = 5'd0;
   localparam logic [4:0] OPC_SUB = 5'd1;
   localparam logic [4:0] OPC_LSF = 5'd2;
   localparam logic [4:0] OPC_RSF = 5'd3;
   localparam logic [4:0] OPC_AND = 5'd4;
   localparam logic [4:0] OPC_OR  = 5'd5;
   localparam logic [4:0] OPC_XOR = 5'd6;
   localparam logic [4:0] OPC_LHI = 5'd7;
   localparam logic [4:0] OPC_LD  = 5'd8;
   localparam logic [4:0] OPC_ST  = 5'd9;
   localparam logic [4:0] OPC_JLT = 5'd16;
   localparam logic [4:0] OPC_JLE = 5'd17;
   localparam logic [4:0] OPC_JEQ = 5'd18;
   localparam logic [4:0] OPC_JNE = 5'd19;
   localparam logic [4:0] OPC_JIN = 5'd20;
   localparam logic [4:0] OPC_HLT = 5'd24;
   localparam logic [4:0] OPC_CPY = 5'd25;
   localparam logic [4:0] OPC_ASK = 5'd26;

   localparam logic [2:0] REG_ZERO = 3'd0;
   localparam logic [2:0] REG_IMM  = 3'd1;
   localparam logic [2:0] REG_LINK = 3'd7;

   typedef struct packed {
      logic [1:0]  spare;
      logic [4:0]  opc;
      logic [2:0]  dst;
      logic [2:0]  src0;
      logic [2:0]  src1;
      logic [15:0] imm;
   } inst_type;

   typedef struct packed {
      logic        en;
      logic [2:0]  idx;
      logic [31:0] data;
   } rf_wr_type;

endpackage

>>> rtl/srce_ram.sv
module srce_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/srce_regfile.sv
module srce_regfile (
   input  logic                  clock,
   input  logic                  reset,
   input  srce_pkg::rf_wr_type   wr,
   input  logic                  rd_en,
   input  logic [2:0]            rd_a_idx,
   input  logic [2:0]            rd_b_idx,
   output logic [31:0]           rd_a_data,
   output logic [31:0]           rd_b_data
);

   // Entries that were never written read as zero.
   logic [7:0]  valid_ff;
   logic        a_valid_ff;
   logic        b_valid_ff;
   logic [31:0] a_raw;
   logic [31:0] b_raw;

   srce_ram #(.WIDTH(32), .DEPTH(8)) u_bank_a (
      .clock   (clock),
      .wr_en   (wr.en),
      .wr_addr (wr.idx),
      .wr_data (wr.data),
      .rd_en   (rd_en),
      .rd_addr (rd_a_idx),
      .rd_data (a_raw)
   );

   srce_ram #(.WIDTH(32), .DEPTH(8)) u_bank_b (
      .clock   (clock),
      .wr_en   (wr.en),
      .wr_addr (wr.idx),
      .wr_data (wr.data),
      .rd_en   (rd_en),
      .rd_addr (rd_b_idx),
      .rd_data (b_raw)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr.en) begin
         valid_ff[wr.idx] <= 1'b1;
      end
      if (rd_en) begin
         a_valid_ff <= valid_ff[rd_a_idx];
         b_valid_ff <= valid_ff[rd_b_idx];
      end
   end

   assign rd_a_data = a_valid_ff ? a_raw : '0;
   assign rd_b_data = b_valid_ff ? b_raw : '0;

endmodule

>>> rtl/small_risc_core_executor.sv
// Small 32-bit processor core driven one transaction at a time.
// Request channel (req_valid/req_ready) carries an operation code, a word address
// and a data word: write a memory word, read a memory word, start the core at
// PC 0, or execute the single instruction at the current PC.
// Every request produces exactly one response transaction on the rsp_ channel,
// reporting read data, the PC afterwards, the halted flag, the executed opcode,
// any register write and whether a store took place.
// Memory write, start and execute while halted complete in the state after acceptance,
// a memory read adds a read-data state, and an instruction passes through fetch from
// main memory, register file read and execute, with a memory address step added for
// stores and loads and a load-data step for loads. A new request is accepted in the
// cycle its predecessor completes.
// A single output register holds the response; the core keeps accepting and working
// while it waits, and only stalls in the completing cycle if the previous response
// has not yet been taken.
// Reset clears the PC, the running flag and the register file. Main memory is not
// cleared and must be written before it is fetched or loaded from.
`include "small_risc_core_executor_assert.svh"

module small_risc_core_executor #(
   parameter int unsigned MEM_WORDS = 65536
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_operation,
   input  logic [15:0] req_address,
   input  logic [31:0] req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_read_data,
   output logic [15:0] rsp_pc_now,
   output logic        rsp_halted,
   output logic [4:0]  rsp_executed_opcode,
   output logic        rsp_reg_written,
   output logic [2:0]  rsp_reg_index,
   output logic [31:0] rsp_reg_value,
   output logic        rsp_mem_written
);

   localparam int unsigned IW = $clog2(MEM_WORDS);
   localparam int unsigned QW = $clog2(65536 / MEM_WORDS + 1);
   localparam logic [63:0] RECIP_W = ((64'd1 << 32) + 64'(MEM_WORDS) - 64'd1) / 64'(MEM_WORDS);
   localparam logic [24:0] RECIP = RECIP_W[24:0];

   typedef enum logic [2:0] {
      S_IDLE, S_MEM, S_RDATA, S_DEC, S_EXE, S_MADDR, S_LOAD
   } state_type;

   typedef enum logic [1:0] {NP_SAME, NP_INC, NP_JUMP} next_pc_type;

   // Address reduction modulo the memory size: the quotient comes from a
   // reciprocal multiply and is registered before the remainder is formed.
   function automatic logic [QW-1:0] addr_quot(input logic [15:0] a);
      logic [40:0] p;
      p = 41'(a) * 41'(RECIP);
      return p[32 +: QW];
   endfunction

   function automatic logic [IW-1:0] addr_rem(input logic [15:0] a, input logic [QW-1:0] q);
      logic [16:0] diff;
      diff = 17'(a) - 17'(q) * 17'(MEM_WORDS);
      return diff[IW-1:0];
   endfunction

   function automatic logic [2:0] port_a_index(input srce_pkg::inst_type inst);
      return (inst.opc == srce_pkg::OPC_LHI) ? inst.dst : inst.src0;
   endfunction

   function automatic logic [31:0] read_operand(input logic [2:0] idx, input logic [31:0] rf,
                                               input logic [31:0] imm);
      logic [31:0] v;
      v = rf;
      if (idx == srce_pkg::REG_ZERO) begin
         v = '0;
      end else if (idx == srce_pkg::REG_IMM) begin
         v = imm;
      end
      return v;
   endfunction

   state_type           state_ff, state_in;
   logic [1:0]          op_ff;
   logic [15:0]         addr_ff;
   logic [QW-1:0]       aq_ff;
   logic [31:0]         wdata_ff;
   logic [15:0]         pc_ff, pc_in;
   logic [IW-1:0]       pcidx_ff, pcidx_in;
   logic                running_ff, running_in;
   srce_pkg::inst_type  inst_ff;
   logic [QW-1:0]       immq_ff;
   logic [15:0]         ma_addr_ff;
   logic [QW-1:0]       ma_q_ff;
   logic [31:0]         st_data_ff;

   logic                rsp_valid_ff;
   logic [31:0]         rsp_read_data_ff, res_read_data;
   logic [15:0]         rsp_pc_now_ff;
   logic                rsp_halted_ff;
   logic [4:0]          rsp_executed_opcode_ff, res_opc;
   logic                rsp_reg_written_ff, res_rw;
   logic [2:0]          rsp_reg_index_ff, res_ridx;
   logic [31:0]         rsp_reg_value_ff, res_rval;
   logic                rsp_mem_written_ff, res_mw;

   logic                space, fin_state, fin, req_take;
   logic                mem_we, mem_re;
   logic [IW-1:0]       mem_waddr, mem_raddr;
   logic [31:0]         mem_wdata, mem_rdata;
   srce_pkg::rf_wr_type rf_wr, rf_wr_req;
   logic                rf_re;
   logic [31:0]         rf_a_data, rf_b_data;
   srce_pkg::inst_type  dec_inst;

   logic [31:0]         ex_imm, ex_a0, ex_a1, ex_wval;
   logic                ex_wr, ex_jump, ex_halt;
   logic [2:0]          ex_widx;
   next_pc_type         ex_np;
   logic [15:0]         pc_inc;
   logic [IW-1:0]       pcidx_inc;

   srce_ram #(.WIDTH(32), .DEPTH(MEM_WORDS)) u_main_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   assign dec_inst = mem_rdata;

   srce_regfile u_regfile (
      .clock     (clock),
      .reset     (reset),
      .wr        (rf_wr),
      .rd_en     (rf_re),
      .rd_a_idx  (port_a_index(dec_inst)),
      .rd_b_idx  (dec_inst.src1),
      .rd_a_data (rf_a_data),
      .rd_b_data (rf_b_data)
   );

   assign pc_inc    = pc_ff + 16'd1;
   assign pcidx_inc = ((pc_ff == 16'hFFFF) || (pcidx_ff == IW'(MEM_WORDS - 1))) ?
                      '0 : pcidx_ff + IW'(1);

   always_comb begin
      ex_imm  = {{16{inst_ff.imm[15]}}, inst_ff.imm};
      ex_a0   = read_operand(port_a_index(inst_ff), rf_a_data, ex_imm);
      ex_a1   = read_operand(inst_ff.src1, rf_b_data, ex_imm);
      ex_wr   = 1'b0;
      ex_wval = '0;
      ex_jump = 1'b0;
      ex_halt = 1'b0;
      ex_np   = NP_INC;
      case (inst_ff.opc)
         srce_pkg::OPC_ADD: begin ex_wr = 1'b1; ex_wval = ex_a0 + ex_a1; end
         srce_pkg::OPC_SUB: begin ex_wr = 1'b1; ex_wval = ex_a0 - ex_a1; end
         srce_pkg::OPC_LSF: begin ex_wr = 1'b1; ex_wval = ex_a0 << ex_a1[4:0]; end
         srce_pkg::OPC_RSF: begin
            ex_wr   = 1'b1;
            ex_wval = $signed(ex_a0) >>> ex_a1[4:0];
         end
         srce_pkg::OPC_AND: begin ex_wr = 1'b1; ex_wval = ex_a0 & ex_a1; end
         srce_pkg::OPC_OR:  begin ex_wr = 1'b1; ex_wval = ex_a0 | ex_a1; end
         srce_pkg::OPC_XOR: begin ex_wr = 1'b1; ex_wval = ex_a0 ^ ex_a1; end
         srce_pkg::OPC_LHI: begin ex_wr = 1'b1; ex_wval = {inst_ff.imm, ex_a0[15:0]}; end
         srce_pkg::OPC_LD, srce_pkg::OPC_ST, srce_pkg::OPC_CPY, srce_pkg::OPC_ASK: begin
            ex_np = NP_INC;
         end
         srce_pkg::OPC_JLT: ex_jump = $signed(ex_a0) < $signed(ex_a1);
         srce_pkg::OPC_JLE: ex_jump = $signed(ex_a0) <= $signed(ex_a1);
         srce_pkg::OPC_JEQ: ex_jump = ex_a0 == ex_a1;
         srce_pkg::OPC_JNE: ex_jump = ex_a0 != ex_a1;
         srce_pkg::OPC_JIN: ex_jump = 1'b1;
         srce_pkg::OPC_HLT: begin ex_np = NP_SAME; ex_halt = 1'b1; end
         default: ex_np = NP_SAME;
      endcase
      ex_widx = inst_ff.dst;
      if (ex_jump) begin
         ex_wr   = 1'b1;
         ex_widx = srce_pkg::REG_LINK;
         ex_wval = {16'd0, pc_ff};
         ex_np   = NP_JUMP;
      end
   end

   always_comb begin
      state_in      = state_ff;
      fin_state     = 1'b0;
      pc_in         = pc_ff;
      pcidx_in      = pcidx_ff;
      running_in    = running_ff;
      mem_we        = 1'b0;
      mem_waddr     = addr_rem(addr_ff, aq_ff);
      mem_wdata     = wdata_ff;
      mem_re        = 1'b0;
      mem_raddr     = addr_rem(addr_ff, aq_ff);
      rf_re         = 1'b0;
      rf_wr_req     = '0;
      res_read_data = '0;
      res_opc       = '0;
      res_mw        = 1'b0;
      case (state_ff)
         S_IDLE: state_in = S_IDLE;
         S_MEM: begin
            case (op_ff)
               srce_pkg::OPN_WRITE: begin
                  mem_we    = 1'b1;
                  fin_state = 1'b1;
               end
               srce_pkg::OPN_READ: begin
                  mem_re   = 1'b1;
                  state_in = S_RDATA;
               end
               srce_pkg::OPN_START: begin
                  pc_in      = '0;
                  pcidx_in   = '0;
                  running_in = 1'b1;
                  fin_state  = 1'b1;
               end
               default: begin
                  if (running_ff) begin
                     mem_re    = 1'b1;
                     mem_raddr = pcidx_ff;
                     state_in  = S_DEC;
                  end else begin
                     fin_state = 1'b1;
                  end
               end
            endcase
         end
         S_RDATA: begin
            res_read_data = mem_rdata;
            fin_state     = 1'b1;
         end
         S_DEC: begin
            rf_re    = 1'b1;
            state_in = S_EXE;
         end
         S_EXE: begin
            res_opc = inst_ff.opc;
            if ((inst_ff.opc == srce_pkg::OPC_LD) || (inst_ff.opc == srce_pkg::OPC_ST)) begin
               state_in = S_MADDR;
            end else begin
               fin_state      = 1'b1;
               rf_wr_req.en   = ex_wr;
               rf_wr_req.idx  = ex_widx;
               rf_wr_req.data = ex_wval;
               running_in     = running_ff & ~ex_halt;
               case (ex_np)
                  NP_INC: begin pc_in = pc_inc; pcidx_in = pcidx_inc; end
                  NP_JUMP: begin
                     pc_in    = inst_ff.imm;
                     pcidx_in = addr_rem(inst_ff.imm, immq_ff);
                  end
                  default: begin pc_in = pc_ff; pcidx_in = pcidx_ff; end
               endcase
            end
         end
         S_MADDR: begin
            res_opc   = inst_ff.opc;
            mem_waddr = addr_rem(ma_addr_ff, ma_q_ff);
            mem_raddr = addr_rem(ma_addr_ff, ma_q_ff);
            mem_wdata = st_data_ff;
            if (inst_ff.opc == srce_pkg::OPC_ST) begin
               mem_we    = 1'b1;
               res_mw    = 1'b1;
               fin_state = 1'b1;
               pc_in     = pc_inc;
               pcidx_in  = pcidx_inc;
            end else begin
               mem_re   = 1'b1;
               state_in = S_LOAD;
            end
         end
         S_LOAD: begin
            res_opc        = inst_ff.opc;
            fin_state      = 1'b1;
            pc_in          = pc_inc;
            pcidx_in       = pcidx_inc;
            rf_wr_req.en   = 1'b1;
            rf_wr_req.idx  = inst_ff.dst;
            rf_wr_req.data = mem_rdata;
         end
         default: state_in = S_IDLE;
      endcase

      space     = ~rsp_valid_ff | rsp_ready;
      fin       = fin_state & space;
      req_ready = (state_ff == S_IDLE) | fin;
      req_take  = req_valid & req_ready;
      mem_we    = mem_we & space;

      rf_wr      = rf_wr_req;
      rf_wr.en   = rf_wr_req.en & fin & (rf_wr_req.idx != srce_pkg::REG_ZERO) &
                   (rf_wr_req.idx != srce_pkg::REG_IMM);
      res_rw     = rf_wr.en;
      res_ridx   = rf_wr.en ? rf_wr.idx : '0;
      res_rval   = rf_wr.en ? rf_wr.data : '0;

      if ((state_ff == S_IDLE) || fin) begin
         state_in = req_take ? S_MEM : S_IDLE;
      end else if (fin_state) begin
         state_in = state_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pc_ff        <= '0;
         pcidx_ff     <= '0;
         running_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (fin) begin
            pc_ff      <= pc_in;
            pcidx_ff   <= pcidx_in;
            running_ff <= running_in;
         end
         if (fin) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (req_take) begin
         op_ff    <= req_operation;
         addr_ff  <= req_address;
         aq_ff    <= addr_quot(req_address);
         wdata_ff <= req_data;
      end
      if (state_ff == S_DEC) begin
         inst_ff <= dec_inst;
         immq_ff <= addr_quot(dec_inst.imm);
      end
      if (state_ff == S_EXE) begin
         ma_addr_ff <= ex_a1[15:0];
         ma_q_ff    <= addr_quot(ex_a1[15:0]);
         st_data_ff <= ex_a0;
      end
      if (fin) begin
         rsp_read_data_ff       <= res_read_data;
         rsp_pc_now_ff          <= pc_in;
         rsp_halted_ff          <= ~running_in;
         rsp_executed_opcode_ff <= res_opc;
         rsp_reg_written_ff     <= res_rw;
         rsp_reg_index_ff       <= res_ridx;
         rsp_reg_value_ff       <= res_rval;
         rsp_mem_written_ff     <= res_mw;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_read_data       = rsp_read_data_ff;
   assign rsp_pc_now          = rsp_pc_now_ff;
   assign rsp_halted          = rsp_halted_ff;
   assign rsp_executed_opcode = rsp_executed_opcode_ff;
   assign rsp_reg_written     = rsp_reg_written_ff;
   assign rsp_reg_index       = rsp_reg_index_ff;
   assign rsp_reg_value       = rsp_reg_value_ff;
   assign rsp_mem_written     = rsp_mem_written_ff;

   `SRCE_ASSERT_IMP(a_exec_needs_run, (state_ff == S_DEC) || (state_ff == S_EXE),
                    running_ff, "instruction in flight while halted")
   `SRCE_ASSERT_IMP(a_pcidx_range, 1'b1, pcidx_ff <= IW'(MEM_WORDS - 1),
                    "fetch index beyond memory")
   `SRCE_ASSERT_IMP(a_rf_fixed_regs, rf_wr.en,
                    (rf_wr.idx != srce_pkg::REG_ZERO) && (rf_wr.idx != srce_pkg::REG_IMM),
                    "write to a fixed register")
   `SRCE_ASSERT_IMP(a_mem_wr_fin, mem_we, fin, "memory written outside a completing cycle")
   `SRCE_ASSERT_NXT(a_accept_start, req_take, state_ff == S_MEM,
                    "accepted transaction not started")

endmodule
